@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define FFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define FFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ src/ffa_pkg.sv @@
// Types and constants of the first-fit heap allocator.
// No dependencies.
package ffa_pkg;
    localparam int AW = 17;
    localparam int SW = 16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOINIT   = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] len;
        logic          in_use;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic wr0;
        logic wr1;
    } t_cell_ctl;
endpackage

@@ src/ffa_if.sv @@
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on nothing.
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] req_size;
    logic [16:0] free_offset;
    modport source (output valid, cmd, req_size, free_offset, input ready);
    modport sink (input valid, cmd, req_size, free_offset, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [16:0] result_offset;
    logic        heap_empty;
    modport source (output valid, status, result_offset, heap_empty, input ready);
    modport sink (input valid, status, result_offset, heap_empty, output ready);
endinterface

interface ffa_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ src/ffa_cell.sv @@
// One entry of the block table chain: holds an entry, takes its right
// neighbor on a shift, or loads one of two tail writes. Depends on ffa_pkg.
module ffa_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              i_clk,
    input  ffa_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]     i_widx,
    input  ffa_pkg::t_entry   i_d0,
    input  ffa_pkg::t_entry   i_d1,
    input  ffa_pkg::t_entry   i_right,
    output ffa_pkg::t_entry   o_entry
);
    import ffa_pkg::*;

    localparam logic [CW-1:0] MY = CW'(IDX);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_right;
        end
        if (i_ctl.wr0 && i_widx == MY) begin
            n_entry = i_d0;
        end else if (i_ctl.wr1 && (i_widx + 1'b1) == MY) begin
            n_entry = i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

@@ src/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: control sequencer and cell chain.
// Depends on ffa_pkg, the channel interfaces and ffa_cell.
//
// The block table lives in a chain of MAX_BLOCKS cells. Each request that passes its
// early checks rotates the whole table once through the head cell, one entry per
// cycle, editing, splitting or merging entries as they pass and pushing them back at
// the tail, so order is kept. A request that fails its early checks goes from idle
// straight to the done state, and the next request can be taken once its result is
// registered and the sequencer is back in idle. Any other request passes through the
// scan, flush and done states before its result is registered, and the next is taken
// after that. A stalled result holds the sequencer in its last state. A configuration
// write re-initializes the heap to one free block, written in the idle state before
// the next request is taken. One request is in work at a time.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_BYTES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ffa_cfg_if.sink   i_cfg,
    ffa_req_if.sink   i_req,
    ffa_rsp_if.source o_rsp
);
    import ffa_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [AW:0] HB = (AW + 1)'(HEADER_BYTES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_heap;
    logic          r_init, n_init;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_bytes, n_bytes;
    logic [CW-1:0] r_q, n_q;
    logic [CW-1:0] r_step, n_step;
    logic          r_cmd, n_cmd;
    logic [AW-1:0] r_need, n_need;
    logic [AW-1:0] r_off, n_off;
    logic          r_done, n_done;
    logic [2:0]    r_status, n_status;
    logic [AW-1:0] r_result, n_result;
    logic          r_pv, n_pv;
    logic          r_pfl, n_pfl;
    t_entry        r_p, n_p;

    logic          r_ovalid, n_ovalid;
    logic [2:0]    r_ostatus, n_ostatus;
    logic [AW-1:0] r_oresult, n_oresult;
    logic          r_oempty, n_oempty;

    t_cell_ctl     w_ctl;
    logic [CW-1:0] w_widx;
    t_entry        w_d0, w_d1;
    t_entry        w_cell [MAX_BLOCKS];
    t_entry        w_h;

    logic [AW:0]   w_need_in;
    logic [AW-1:0] w_rest;
    logic          w_fit, w_hit, w_merge;
    logic          w_req_acc, w_cfg_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
            ffa_cell #(.IDX(gi), .CW(CW)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_widx (w_widx),
                .i_d0   (w_d0),
                .i_d1   (w_d1),
                .i_right((gi == MAX_BLOCKS - 1) ? w_cell[gi] : w_cell[(gi + 1) % MAX_BLOCKS]),
                .o_entry(w_cell[gi])
            );
        end
    endgenerate

    assign w_h       = w_cell[0];
    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc = i_cfg.valid;
    assign i_req.ready = (r_state == S_IDLE) && !r_init;
    assign w_req_acc = i_req.valid && i_req.ready;
    assign w_need_in = {2'b0, i_req.req_size} + HB;

    assign w_rest  = w_h.len - r_need;
    assign w_fit   = !r_done && !w_h.in_use && ({1'b0, w_h.len} >= ({1'b0, r_need} + HB));
    assign w_hit   = !r_done && w_h.in_use && (({1'b0, w_h.start} + HB) == {1'b0, r_off});

    always_comb begin
        t_entry h2;
        logic   fl2;
        h2        = w_h;
        fl2       = 1'b0;
        n_state   = r_state;
        n_init    = r_init;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_q       = r_q;
        n_step    = r_step;
        n_cmd     = r_cmd;
        n_need    = r_need;
        n_off     = r_off;
        n_done    = r_done;
        n_status  = r_status;
        n_result  = r_result;
        n_pv      = r_pv;
        n_pfl     = r_pfl;
        n_p       = r_p;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_oresult = r_oresult;
        n_oempty  = r_oempty;
        w_ctl     = '0;
        w_widx    = '0;
        w_d0      = w_h;
        w_d1      = w_h;
        w_merge   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (r_init) begin
                    w_ctl.wr0  = 1'b1;
                    w_d0.start = '0;
                    w_d0.len   = AW'({2'b0, r_heap} + HB);
                    w_d0.in_use = 1'b0;
                    n_init     = 1'b0;
                end else if (w_req_acc) begin
                    n_cmd    = i_req.cmd;
                    n_need   = w_need_in[AW-1:0];
                    n_off    = i_req.free_offset;
                    n_result = '0;
                    n_done   = 1'b0;
                    n_pv     = 1'b0;
                    n_pfl    = 1'b0;
                    n_q      = r_count;
                    n_step   = r_count;
                    n_state  = S_SCAN;
                    n_status = (i_req.cmd == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
                    if (r_heap == '0) begin
                        n_status = ST_NOINIT;
                        n_state  = S_DONE;
                    end else if (i_req.cmd == CMD_ALLOC) begin
                        if (i_req.req_size == '0) begin
                            n_status = ST_ZERO;
                            n_state  = S_DONE;
                        end else if (({1'b0, r_bytes} + w_need_in) > {2'b0, r_heap}) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_step == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_step      = r_step - 1'b1;
                    w_ctl.shift = 1'b1;
                    w_widx      = r_q - 1'b1;
                    n_q         = r_q - 1'b1;
                    if (r_cmd == CMD_ALLOC) begin
                        w_ctl.wr0 = 1'b1;
                        if (w_fit) begin
                            n_done = 1'b1;
                            if (w_rest != '0 && r_count >= MAXC) begin
                                n_status = ST_NOSPACE;
                                n_q      = r_q;
                            end else begin
                                n_status  = ST_OK;
                                n_result  = AW'({1'b0, w_h.start} + HB);
                                n_bytes   = r_bytes + r_need;
                                w_d0.len  = r_need;
                                w_d0.in_use = 1'b1;
                                if (w_rest != '0) begin
                                    w_ctl.wr1   = 1'b1;
                                    w_d1.start  = w_h.start + r_need;
                                    w_d1.len    = w_rest;
                                    w_d1.in_use = 1'b0;
                                    n_q         = r_q + 1'b1;
                                end else begin
                                    n_q = r_q;
                                end
                            end
                        end else begin
                            n_q = r_q;
                        end
                    end else begin
                        if (w_hit) begin
                            n_done    = 1'b1;
                            n_status  = ST_OK;
                            n_bytes   = r_bytes - w_h.len;
                            h2.in_use = 1'b0;
                            fl2       = 1'b1;
                        end
                        w_merge = r_pv && !r_p.in_use && !h2.in_use && (r_pfl || fl2);
                        if (w_merge) begin
                            n_p.len = r_p.len + h2.len;
                            n_pfl   = fl2;
                        end else begin
                            if (r_pv) begin
                                w_ctl.wr0 = 1'b1;
                                w_d0      = r_p;
                                n_q       = r_q;
                            end
                            n_pv  = 1'b1;
                            n_p   = h2;
                            n_pfl = fl2;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (r_pv) begin
                    w_ctl.wr0 = 1'b1;
                    w_widx    = r_q;
                    w_d0      = r_p;
                    n_count   = r_q + 1'b1;
                end else begin
                    n_count = r_q;
                end
                n_pv    = 1'b0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oresult = (r_status == ST_OK) ? r_result : '0;
                    n_oempty  = (r_bytes == '0);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cfg_acc) begin
            n_init  = 1'b1;
            n_count = CW'(1);
            n_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_heap   <= '0;
            r_init   <= 1'b1;
            r_count  <= CW'(1);
            r_bytes  <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
            if (w_cfg_acc) begin
                r_heap <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_step    <= n_step;
        r_cmd     <= n_cmd;
        r_need    <= n_need;
        r_off     <= n_off;
        r_done    <= n_done;
        r_status  <= n_status;
        r_result  <= n_result;
        r_pfl     <= n_pfl;
        r_p       <= n_p;
        r_ostatus <= n_ostatus;
        r_oresult <= n_oresult;
        r_oempty  <= n_oempty;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.result_offset = r_oresult;
    assign o_rsp.heap_empty    = r_oempty;
endmodule

@@ src/ffa_checker.sv @@
// Port-level checks of the first-fit heap allocator, bound to the top level.
// Depends on ffa_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [16:0] rsp_offset
);
    import ffa_pkg::*;

    `FFA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")
    `FFA_ASSERT_SAME(a_status_range, i_clk, i_rst_n, rsp_valid, rsp_status <= ST_NOTFOUND, "status code out of range")
    `FFA_ASSERT_SAME(a_offset_zero, i_clk, i_rst_n, rsp_valid && rsp_status != ST_OK, rsp_offset == '0, "failed request returned an offset")
    `FFA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, req_valid && req_ready, !req_ready, "request taken while another is in work")
endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .rsp_valid (o_rsp.valid),
    .rsp_ready (o_rsp.ready),
    .rsp_status(o_rsp.status),
    .rsp_offset(o_rsp.result_offset)
);
